// ----- rtl/pksc_pkg.sv -----
// Package for the per-key stride checker.
// Field widths, parameter defaults, occurrence and table mode codes.
// No dependencies.
package pksc_pkg;

  localparam int KeyW              = 10;
  localparam int PeriodW           = 16;
  localparam int KEY_COUNT_DEF     = 1024;
  localparam int POSITION_BITS_DEF = 16;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_ONCE   = 2'd1,
    ST_EVEN   = 2'd2,
    ST_BROKEN = 2'd3
  } occ_e;

  typedef enum logic {
    MODE_CLEAR = 1'b0,
    MODE_RUN   = 1'b1
  } mode_e;

endpackage

// ----- rtl/pksc_table.sv -----
// Key table of the per-key stride checker: occurrence state memory with a
// clearing sweep after reset, and an uncleared memory of last position and stride.
// Depends on pksc_pkg.
module pksc_table
  import pksc_pkg::*;
#(
  parameter int KEY_COUNT     = KEY_COUNT_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  localparam int IdxW         = $clog2(KEY_COUNT)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  output logic                     clearing_o,
  input  logic                     rd_en_i,
  input  logic [IdxW-1:0]          rd_idx_i,
  output occ_e                     rd_state_o,
  output logic [POSITION_BITS-1:0] rd_last_o,
  output logic [POSITION_BITS-1:0] rd_stride_o,
  input  logic                     wr_en_i,
  input  logic [IdxW-1:0]          wr_idx_i,
  input  occ_e                     wr_state_i,
  input  logic [POSITION_BITS-1:0] wr_last_i,
  input  logic [POSITION_BITS-1:0] wr_stride_i
);

  occ_e                         st_mem [KEY_COUNT];
  logic [2*POSITION_BITS-1:0]   pos_mem [KEY_COUNT];
  logic [2*POSITION_BITS-1:0]   pos_rd_q;
  occ_e                         st_rd_q;
  mode_e                        mode_q, mode_d;
  logic [IdxW-1:0]              clr_idx_q, clr_idx_d;

  always_comb begin
    mode_d = mode_q;
    case (mode_q)
      MODE_CLEAR: if (clr_idx_q == IdxW'(KEY_COUNT - 1)) mode_d = MODE_RUN;
      MODE_RUN:   mode_d = MODE_RUN;
      default:    mode_d = MODE_CLEAR;
    endcase
  end

  always_comb begin
    clearing_o = 1'b0;
    clr_idx_d  = clr_idx_q;
    case (mode_q)
      MODE_CLEAR: begin
        clearing_o = 1'b1;
        clr_idx_d  = clr_idx_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_CLEAR;
      clr_idx_q <= '0;
    end else begin
      mode_q    <= mode_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_o) begin
      st_mem[clr_idx_q] <= ST_NONE;
    end else if (wr_en_i) begin
      st_mem[wr_idx_i] <= wr_state_i;
    end
    if (rd_en_i) begin
      st_rd_q <= st_mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pos_mem[wr_idx_i] <= {wr_stride_i, wr_last_i};
    end
    if (rd_en_i) begin
      pos_rd_q <= pos_mem[rd_idx_i];
    end
  end

  assign rd_state_o  = st_rd_q;
  assign rd_last_o   = pos_rd_q[POSITION_BITS-1:0];
  assign rd_stride_o = pos_rd_q[2*POSITION_BITS-1:POSITION_BITS];

endmodule

// ----- rtl/per_key_stride_checker.sv -----
// Channel   Handshake            Ports
// command   start_i, busy_o      action_i, key_i
// result    done_o (strobe)      occurred_o, uniform_o, period_o, overflow_o
//
// One transaction a cycle while busy_o is low; after acceptance its result
// strobes after a table read, then update and write back. Back-to-back hits on
// the same key use the last write's forwarded entry.
// After reset busy_o stays high while the state memory is swept clear.
// Results cannot be stalled.
// Depends on pksc_pkg and pksc_table.
module per_key_stride_checker
  import pksc_pkg::*;
#(
  parameter int KEY_COUNT     = KEY_COUNT_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               action_i,
  input  logic [KeyW-1:0]    key_i,
  output logic               done_o,
  output logic               occurred_o,
  output logic               uniform_o,
  output logic [PeriodW-1:0] period_o,
  output logic               overflow_o
);

  localparam int IdxW = $clog2(KEY_COUNT);
  localparam int PosW = POSITION_BITS;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  logic            accept;
  logic            clearing;
  occ_e            rd_state;
  logic [PosW-1:0] rd_last, rd_stride;

  logic            s1_valid_q, s1_action_q, s1_inr_q;
  logic [IdxW-1:0] s1_idx_q;

  logic            fwd_valid_q;
  logic [IdxW-1:0] fwd_idx_q;
  occ_e            fwd_state_q;
  logic [PosW-1:0] fwd_last_q, fwd_stride_q;

  logic [PosW-1:0] pos_q, pos_d;
  logic            ovf_q, ovf_d;

  logic            hit, record;
  occ_e            cur_state, new_state, rep_state;
  logic [PosW-1:0] cur_last, cur_stride, new_stride, gap;
  logic [PeriodW-1:0] rep_period;

  logic               done_q, occ_q, uni_q, ovf_out_q;
  logic [PeriodW-1:0] period_q;

  assign busy_o = clearing;
  assign accept = start_i && !busy_o;

  pksc_table #(
    .KEY_COUNT    (KEY_COUNT),
    .POSITION_BITS(POSITION_BITS)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clearing_o  (clearing),
    .rd_en_i     (accept),
    .rd_idx_i    (IdxW'(key_i)),
    .rd_state_o  (rd_state),
    .rd_last_o   (rd_last),
    .rd_stride_o (rd_stride),
    .wr_en_i     (record),
    .wr_idx_i    (s1_idx_q),
    .wr_state_i  (new_state),
    .wr_last_i   (pos_q),
    .wr_stride_i (new_stride)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_action_q <= action_i;
      s1_idx_q    <= IdxW'(key_i);
      s1_inr_q    <= (32'(key_i) < KEY_COUNT);
    end
  end

  assign hit        = fwd_valid_q && (fwd_idx_q == s1_idx_q);
  assign cur_state  = hit ? fwd_state_q : rd_state;
  assign cur_last   = hit ? fwd_last_q : rd_last;
  assign cur_stride = hit ? fwd_stride_q : rd_stride;
  assign record     = s1_valid_q && !s1_action_q && s1_inr_q;
  assign gap        = pos_q - cur_last;

  always_comb begin
    new_state  = cur_state;
    new_stride = cur_stride;
    case (cur_state)
      ST_NONE: new_state = ST_ONCE;
      ST_ONCE: begin
        new_state  = ST_EVEN;
        new_stride = gap;
      end
      ST_EVEN: if (gap != cur_stride) new_state = ST_BROKEN;
      default: ;
    endcase
  end

  always_comb begin
    pos_d = pos_q;
    ovf_d = ovf_q;
    if (record) begin
      if (pos_q == PosMax) begin
        ovf_d = 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_comb begin
    rep_state  = ST_NONE;
    rep_period = '0;
    if (s1_inr_q) begin
      rep_state = record ? new_state : cur_state;
    end
    if (rep_state == ST_EVEN) begin
      rep_period = (33'(new_stride) > 33'(16'hFFFF)) ? 16'hFFFF : PeriodW'(new_stride);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      fwd_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      fwd_valid_q <= record;
      done_q      <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (record) begin
      fwd_idx_q    <= s1_idx_q;
      fwd_state_q  <= new_state;
      fwd_last_q   <= pos_q;
      fwd_stride_q <= new_stride;
    end
    if (s1_valid_q) begin
      occ_q     <= (rep_state != ST_NONE);
      uni_q     <= (rep_state == ST_ONCE) || (rep_state == ST_EVEN);
      period_q  <= rep_period;
      ovf_out_q <= ovf_d;
    end
  end

  assign done_o     = done_q;
  assign occurred_o = occ_q;
  assign uniform_o  = uni_q;
  assign period_o   = period_q;
  assign overflow_o = ovf_out_q;

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("result strobe missing two cycles after acceptance");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(accept))
    else $error("table stage active without an accepted transaction");

  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

  a_no_record_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !record)
    else $error("table write during clearing sweep");

  a_period_implies_uniform: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (period_o != '0) |-> uniform_o && occurred_o)
    else $error("nonzero period on a non-uniform key");

endmodule
